/* hdl/bounded_fifo_with_search_defines.svh */
// Assertion macros used by the checker of the search FIFO.
// Each macro checks on the rising edge of clk and is quiet while rst_n is low.
`ifndef BOUNDED_FIFO_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_FIFO_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define BFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfs assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define BFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfs assertion failed");

`endif

/* hdl/bfs_pkg.sv */
// ----------------------------------------------------------------------------
// bfs_pkg
// Types and codes shared by the search FIFO, its entry RAM and its checker.
// ----------------------------------------------------------------------------
package bfs_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int CNT_W   = 5;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SEARCH = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SEARCH = 2'd1,
        S_HOLD   = 2'd2
    } fsm_t;

    // kind stays a raw code: the unused code 3 must pass through untouched
    typedef struct packed {
        logic [1:0] kind;
        value_t     value;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] count;
    } rsp_t;

endpackage

/* hdl/bfs_ram.sv */
// ----------------------------------------------------------------------------
// bfs_ram
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bfs_ram
    import bfs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  value_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output value_t        rd_data
);

    value_t mem [DEPTH];
    value_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/bounded_fifo_with_search.sv */
// Bounded FIFO of signed 32-bit values with linear search.
// Request channel (req_valid/req_ready/req_data) carries one beat per
// operation: insert at tail, remove oldest, or search for a value.
// Response channel (rsp_valid/rsp_ready/rsp_data) returns exactly one beat
// per request, in order, with status, found flag, position and count.
// Insert, remove, an unused kind and a search of an empty list answer through
// the response register without a scan. A search over N stored entries reads
// them from the oldest and stops at the first match, then answers through the
// response register; the scan reads one entry per cycle through the
// single read port of the entry RAM, so that port sets the search time.
// Throughput: one insert/remove per cycle while responses drain; a search
// blocks new requests until its scan ends.
// Reset clears head, tail, count and the handshake state at once; the
// entry RAM is not cleared (no clearing pass) since only stored entries
// are ever compared. A stalled receiver parks a finished result in a pending
// register; new requests wait until that result moves to the output.
// ----------------------------------------------------------------------------
// bounded_fifo_with_search
// Top level: ring pointers, search sequencer and response register.
// ----------------------------------------------------------------------------
module bounded_fifo_with_search
    import bfs_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    // control state
    fsm_t          state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // payload
    value_t        key_reg, key_next;
    rsp_t          rsp_data_reg, rsp_data_next;
    rsp_t          pend_reg, pend_next;

    // RAM ports
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    value_t        rd_data;

    // combinational helpers
    logic          accept;
    logic          out_free;
    logic          res_done;
    rsp_t          res;
    logic [CW-1:0] idx_plus1;
    logic [AW-1:0] head_inc, tail_inc, scan_inc;

    bfs_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (req_data.value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ring pointer increments wrap at DEPTH, which need not be a power of two
    assign head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
    assign scan_inc  = (scan_reg == LAST_SLOT) ? '0 : scan_reg + 1'b1;
    assign idx_plus1 = CW'(idx_reg) + CW'(1);

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        rsp_data_reg <= rsp_data_next;
        pend_reg     <= pend_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        pend_next      = pend_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg;
        wr_en          = 1'b0;
        rd_addr        = head_reg;
        res_done       = 1'b0;
        res.status     = ST_DONE;
        res.found      = 1'b0;
        res.position   = '0;
        res.count      = '0;

        // drop the output beat once the receiver takes it
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_data.kind)
                        KIND_INSERT:
                        begin
                            res_done = 1'b1;
                            if (count_reg == FULL_CNT)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                tail_next  = tail_inc;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            res_done = 1'b1;
                            if (count_reg == '0)
                            begin
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        KIND_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_done   = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                // fetch the oldest entry; its data shows next cycle
                                rd_addr    = head_reg;
                                scan_next  = head_inc;
                                idx_next   = '0;
                                key_next   = req_data.value;
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            res_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // compare entry idx_reg while fetching the one after it
                rd_addr   = scan_reg;
                scan_next = scan_inc;
                idx_next  = idx_reg + 1'b1;
                if (rd_data == key_reg)
                begin
                    res_done     = 1'b1;
                    res.found    = 1'b1;
                    res.position = POS_W'(idx_plus1);
                end
                else if (idx_plus1 == count_reg)
                begin
                    res_done = 1'b1;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    rsp_data_next  = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.count = CNT_W'(count_next);

        // move a finished result to the output, or park it while the receiver stalls
        if (res_done)
        begin
            if (out_free)
            begin
                rsp_data_next  = res;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                pend_next  = res;
                state_next = S_HOLD;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

/* hdl/bfs_checker.sv */
// ----------------------------------------------------------------------------
// bfs_checker
// Port-level checks on the search FIFO, bound to every instance of it.
// ----------------------------------------------------------------------------
`include "bounded_fifo_with_search_defines.svh"

module bfs_checker
    import bfs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req_data,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // a stalled response beat holds its payload
    `BFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

    // a match always reports a nonzero position and a done status
    `BFS_ASSERT_NOW(a_found_pos, rsp_valid && rsp_data.found, rsp_data.position != '0 && rsp_data.status == ST_DONE)

    // no match means no position
    `BFS_ASSERT_NOW(a_miss_pos, rsp_valid && !rsp_data.found, rsp_data.position == '0)

    // a refused operation carries no search result
    `BFS_ASSERT_NOW(a_refused, rsp_valid && (rsp_data.status == ST_FULL || rsp_data.status == ST_EMPTY), !rsp_data.found)

endmodule

bind bounded_fifo_with_search bfs_checker u_bfs_checker (.*);

/* test/tb_bounded_fifo_with_search.sv */
// ----------------------------------------------------------------------------
// tb_bounded_fifo_with_search
// Self-checking bench for the search FIFO: drives operation beats through a
// valid/ready request channel, predicts every response beat in a behavioral
// model of the list and compares each returned beat field by field.
// ----------------------------------------------------------------------------
module tb_bounded_fifo_with_search;

    import bfs_pkg::*;

    localparam int FIFO_DEPTH     = 16;
    localparam int RESET_CYCLES   = 11;
    localparam int BATCH_LEN      = 40;
    localparam int BATCHES        = 15;
    localparam int LONG_STALL     = 300;
    localparam int SETTLE_CYCLES  = FIFO_DEPTH + 24;
    localparam int WATCHDOG_LIMIT = 5000;

    // the package names only the three real operations
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam value_t VAL_MIN = 32'sh8000_0000;
    localparam value_t VAL_MAX = 32'sh7fff_ffff;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req_data;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp_data;

    // operations waiting to be offered, and responses predicted but not seen
    req_t   pending_ops[$];
    rsp_t   expected_rsps[$];

    // behavioral copy of the list: ring storage, oldest slot and fill level
    value_t list_vals[FIFO_DEPTH];
    int     list_head;
    int     list_count;

    int     ops_queued;
    int     ops_accepted;
    int     fail_count;
    int     quiet_cycles;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     stall_requests;
    int     stall_served;
    int     stall_left;
    bit     req_taken;
    bit     rsp_taken;
    rsp_t   want;

    value_t value_pool[8];

    bounded_fifo_with_search #(
        .DEPTH (FIFO_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predict the response of one operation and advance the list copy.
    // Only occupied slots are scanned, so a never-written slot is never read.
    // ------------------------------------------------------------------------
    function automatic rsp_t apply_op(req_t op);
        rsp_t r;
        int   i;
        r        = '0;
        r.status = ST_DONE;
        case (op.kind)
            KIND_INSERT:
            begin
                if (list_count >= FIFO_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    list_vals[(list_head + list_count) % FIFO_DEPTH] = op.value;
                    list_count++;
                end
            end
            KIND_REMOVE:
            begin
                if (list_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    list_head = (list_head + 1) % FIFO_DEPTH;
                    list_count--;
                end
            end
            KIND_SEARCH:
            begin
                if (list_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // stop at the first match, counted from 1 at the oldest
                    for (i = 0; i < list_count && !r.found; i++)
                    begin
                        if (list_vals[(list_head + i) % FIFO_DEPTH] == op.value)
                        begin
                            r.found    = 1'b1;
                            r.position = POS_W'(i + 1);
                        end
                    end
                end
            end
            default:
            begin
                // unused code: no change, plain done with the current count
            end
        endcase
        r.count = CNT_W'(list_count);
        return r;
    endfunction

    task automatic add_op(input logic [1:0] kind, input value_t value);
        req_t op;
        op.kind  = kind;
        op.value = value;
        pending_ops.push_back(op);
        ops_queued++;
    endtask

    // mostly pool values so that searches hit and duplicates pile up
    function automatic value_t pick_value();
        if ($urandom_range(99) < 70)
            return value_pool[$urandom_range(7)];
        return value_t'($urandom);
    endfunction

    // Queue a batch; insert-heavy batches walk the list toward full,
    // remove-heavy ones walk it back down toward empty.
    task automatic add_random_batch(input bit fill_up);
        int n;
        int pick;
        int ins_pct;
        int rem_pct;
        ins_pct = fill_up ? 55 : 15;
        rem_pct = fill_up ? 15 : 55;
        for (n = 0; n < BATCH_LEN; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                add_op(KIND_UNUSED, value_t'($urandom));
            else if (pick < 3 + ins_pct)
                add_op(KIND_INSERT, pick_value());
            else if (pick < 3 + ins_pct + rem_pct)
                add_op(KIND_REMOVE, value_t'($urandom));
            else
                add_op(KIND_SEARCH, pick_value());
        end
    endtask

    // Hold the sender until every queued beat is taken and answered.
    task automatic wait_for_drain();
        while (ops_accepted != ops_queued || expected_rsps.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        int b;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (b = 0; b < BATCHES; b++)
        begin
            add_random_batch(b % 2 == 0);
            if (b % 5 == 4)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------------
    // Request driver: advance to the next beat once the current one is taken.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_data  <= pending_ops.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response receiver: random back-pressure, plus a long hold-off whenever
    // one is requested, counted down here so the block backs up fully.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (stall_requests != stall_served)
            begin
                stall_served++;
                stall_left = LONG_STALL - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: record taken request beats, check response beats against the
    // oldest prediction, and watch for a stuck handshake.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken = req_valid && req_ready;
            rsp_taken = rsp_valid && rsp_ready;
            if (req_taken)
            begin
                expected_rsps.push_back(apply_op(req_data));
                ops_accepted++;
            end
            if (rsp_taken)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("response beat with nothing expected: %h", rsp_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status,
                               rsp_data.status);
                        fail_count++;
                    end
                    if (rsp_data.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found,
                               rsp_data.found);
                        fail_count++;
                    end
                    if (rsp_data.position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position,
                               rsp_data.position);
                        fail_count++;
                    end
                    if (rsp_data.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count,
                               rsp_data.count);
                        fail_count++;
                    end
                end
            end
            if (req_taken || rsp_taken)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("FAIL bounded_fifo_with_search");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence and end of run.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_data       = '0;
        rsp_ready      = 1'b0;
        list_head      = 0;
        list_count     = 0;
        ops_queued     = 0;
        ops_accepted   = 0;
        fail_count     = 0;
        quiet_cycles   = 0;
        stall_requests = 0;
        stall_served   = 0;
        stall_left     = 0;
        req_taken      = 1'b0;
        rsp_taken      = 1'b0;
        send_idle_pct  = 11;
        recv_idle_pct  = 80;

        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        value_pool[4] = 32'sd1;
        value_pool[5] = 32'sh5555_5555;
        value_pool[6] = 32'shAAAA_AAAA;
        value_pool[7] = 32'sd42;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty-list refusals, the unused code, field extremes,
        // duplicate entries, a miss, and first-match order after a remove
        add_op(KIND_SEARCH, VAL_MIN);
        add_op(KIND_REMOVE, VAL_MAX);
        add_op(KIND_UNUSED, VAL_MAX);
        add_op(KIND_INSERT, VAL_MIN);
        add_op(KIND_INSERT, VAL_MAX);
        add_op(KIND_INSERT, 32'sd0);
        add_op(KIND_INSERT, -32'sd1);
        add_op(KIND_INSERT, VAL_MIN);
        add_op(KIND_SEARCH, VAL_MIN);
        add_op(KIND_SEARCH, -32'sd1);
        add_op(KIND_SEARCH, 32'sh1234_5678);
        add_op(KIND_UNUSED, -32'sd1);
        add_op(KIND_REMOVE, 32'sd0);
        add_op(KIND_SEARCH, VAL_MIN);
        add_op(KIND_SEARCH, VAL_MAX);
        wait_for_drain();

        // fast sender against a slow receiver, then the reverse
        run_phase(11, 80);
        run_phase(80, 11);

        // no idling; open with a long receiver hold-off so the block fills
        // and stalls its input while the sender keeps offering beats
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_requests++;
        add_random_batch(1'b1);
        wait_for_drain();
        run_phase(0, 0);

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_rsps.size() != 0)
        begin
            $error("%0d response beats never arrived", expected_rsps.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("PASS bounded_fifo_with_search");
        else
            $display("FAIL bounded_fifo_with_search");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/bfs_pkg.sv
hdl/bfs_ram.sv
hdl/bounded_fifo_with_search.sv
hdl/bfs_checker.sv
test/tb_bounded_fifo_with_search.sv
